// ----- rtl/mtfne_pkg.sv -----
// mtfne_pkg: shared types, constants and the default table contents
// for the move-to-front nibble coder. No dependencies.
package mtfne_pkg;

	localparam int TableSizeMax = 15;
	localparam int TableSizeDef = 15;
	localparam int ByteW        = 8;
	localparam int NibW         = 4;

	localparam logic [NibW-1:0] EscNibble = 4'hF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ONE,
		ST_FIRST,
		ST_SECOND
	} state_t;

	typedef struct packed {
		logic load;
		logic sel_second;
	} cmd_t;

	typedef struct packed {
		logic [1:0] n_next;
	} status_t;

	function automatic logic [ByteW-1:0] default_char(input logic [NibW-1:0] idx);
		logic [ByteW-1:0] c;
		case (idx)
			4'd0:    c = 8'h20; // ' '
			4'd1:    c = 8'h65; // e
			4'd2:    c = 8'h74; // t
			4'd3:    c = 8'h6F; // o
			4'd4:    c = 8'h61; // a
			4'd5:    c = 8'h73; // s
			4'd6:    c = 8'h72; // r
			4'd7:    c = 8'h69; // i
			4'd8:    c = 8'h6E; // n
			4'd9:    c = 8'h63; // c
			4'd10:   c = 8'h6C; // l
			4'd11:   c = 8'h6D; // m
			4'd12:   c = 8'h68; // h
			4'd13:   c = 8'h64; // d
			4'd14:   c = 8'h75; // u
			default: c = 8'h20;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/mtf_nibble_encoder.sv -----
// mtf_nibble_encoder: top level of the move-to-front nibble coder.
// Depends on mtfne_pkg, mtfne_ctrl and mtfne_dp.
//
//   channel | signals                              | word
//   in      | in_valid, in_ready, in_byte          | one raw byte
//   out     | out_valid, out_ready, out_byte,      | one packed byte, last_of_run
//           | last_of_run                          | marks the final one per input
//
// An input word is taken when in_valid and in_ready are high; its n result
// words (n = 0, 1 or 2) then go out one per cycle while out_ready stays high.
// The controller serialises the result words from two registers.
// arst_n restores the default table and empties the accumulator.
// A stall on out holds the current result word and in_ready stays low.
module mtf_nibble_encoder #(
	parameter int TABLE_SIZE = mtfne_pkg::TableSizeDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mtfne_pkg::ByteW-1:0] in_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mtfne_pkg::ByteW-1:0] out_byte,
	output logic                        last_of_run
);

	mtfne_pkg::cmd_t    cmd;
	mtfne_pkg::status_t status;

	mtfne_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.last_of_run (last_of_run),
		.status      (status),
		.cmd         (cmd)
	);

	mtfne_dp #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_byte  (in_byte),
		.out_byte (out_byte)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	a_free_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_of_run) |=> in_ready)
		else $error("not ready after final result");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_run) |=> (out_valid && last_of_run))
		else $error("second result missing");

endmodule

// ----- rtl/mtfne_dp.sv -----
// mtfne_dp: datapath - move-to-front table cells, parallel search,
// nibble accumulator and result word registers. Uses mtfne_pkg.
module mtfne_dp #(
	parameter int TABLE_SIZE = mtfne_pkg::TableSizeDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mtfne_pkg::cmd_t               cmd,
	output mtfne_pkg::status_t            status,
	input  logic [mtfne_pkg::ByteW-1:0]   in_byte,
	output logic [mtfne_pkg::ByteW-1:0]   out_byte
);

	logic [mtfne_pkg::ByteW-1:0] tbl_q [TABLE_SIZE];
	logic [mtfne_pkg::ByteW-1:0] tbl_d [TABLE_SIZE];
	logic [mtfne_pkg::NibW-1:0]  pend_q, pend_d;
	logic                        full_q, full_d;
	logic [mtfne_pkg::ByteW-1:0] r0_q, r1_q, r0_d, r1_d;
	logic [mtfne_pkg::NibW-1:0]  idx, pos;
	logic                        hit;
	logic [1:0]                  n_d;

	// first match wins
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
			if (tbl_q[i] == in_byte) begin
				hit = 1'b1;
				idx = mtfne_pkg::NibW'(i);
			end
		end
		pos = hit ? idx : mtfne_pkg::NibW'(TABLE_SIZE - 1);
	end

	always_comb begin
		tbl_d[0] = in_byte;
		for (int i = 1; i < TABLE_SIZE; i++) begin
			tbl_d[i] = (mtfne_pkg::NibW'(i) <= pos) ? tbl_q[i-1] : tbl_q[i];
		end
	end

	always_comb begin
		r0_d   = '0;
		r1_d   = in_byte;
		pend_d = pend_q;
		full_d = full_q;
		n_d    = 2'd0;
		case ({hit, full_q})
			2'b10: begin
				pend_d = idx;
				full_d = 1'b1;
				n_d    = 2'd0;
			end
			2'b11: begin
				r0_d   = {idx, pend_q};
				full_d = 1'b0;
				n_d    = 2'd1;
			end
			2'b00: begin
				r0_d   = {in_byte[3:0], mtfne_pkg::EscNibble};
				pend_d = in_byte[7:4];
				full_d = 1'b1;
				n_d    = 2'd1;
			end
			2'b01: begin
				r0_d   = {mtfne_pkg::EscNibble, pend_q};
				full_d = 1'b0;
				n_d    = 2'd2;
			end
			default: begin
				n_d = 2'd0;
			end
		endcase
	end

	assign status.n_next = n_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++) begin
				tbl_q[i] <= mtfne_pkg::default_char(mtfne_pkg::NibW'(i));
			end
			pend_q <= '0;
			full_q <= 1'b0;
		end else if (cmd.load) begin
			tbl_q  <= tbl_d;
			pend_q <= pend_d;
			full_q <= full_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r0_q <= r0_d;
			r1_q <= r1_d;
		end
	end

	assign out_byte = cmd.sel_second ? r1_q : r0_q;

endmodule

// ----- rtl/mtfne_ctrl.sv -----
// mtfne_ctrl: controller FSM - takes one word, then hands out its
// zero to two result words. Uses mtfne_pkg.
module mtfne_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               last_of_run,
	input  mtfne_pkg::status_t status,
	output mtfne_pkg::cmd_t    cmd
);

	mtfne_pkg::state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mtfne_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (status.n_next)
						2'd1:    state_d = mtfne_pkg::ST_ONE;
						2'd2:    state_d = mtfne_pkg::ST_FIRST;
						default: state_d = mtfne_pkg::ST_IDLE;
					endcase
				end
			end
			mtfne_pkg::ST_FIRST: begin
				if (out_ready) state_d = mtfne_pkg::ST_SECOND;
			end
			mtfne_pkg::ST_ONE, mtfne_pkg::ST_SECOND: begin
				if (out_ready) state_d = mtfne_pkg::ST_IDLE;
			end
			default: state_d = mtfne_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == mtfne_pkg::ST_IDLE);
		out_valid      = (state_q != mtfne_pkg::ST_IDLE);
		last_of_run    = state_q inside {mtfne_pkg::ST_ONE, mtfne_pkg::ST_SECOND};
		cmd.load       = (state_q == mtfne_pkg::ST_IDLE) && in_valid;
		cmd.sel_second = (state_q == mtfne_pkg::ST_SECOND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtfne_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- tb/sv/tb_mtf_nibble_encoder.sv -----
// tb_mtf_nibble_encoder: self-checking bench for the move-to-front nibble coder,
// a directed table then random bytes, with random idling and a long output stall.
// Depends on mtfne_pkg and mtf_nibble_encoder.
module tb_mtf_nibble_encoder;

	localparam int TBL      = mtfne_pkg::TableSizeDef;
	localparam int N_DIR    = 23;
	localparam int N_RAND   = 450;
	localparam int LIMIT    = 200000;
	localparam int DRAIN    = 20;
	localparam int LONG_HLD = 400;
	localparam logic [15*mtfne_pkg::ByteW-1:0] DEF_LIST = " etoasrinclmhdu";

	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		logic [1:0] n;
		logic [7:0] e0;
		logic [7:0] e1;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} coded_word_t;

	// rows with typed results start from reset and must stay first
	localparam stim_row_t [0:N_DIR-1] DIR_ROWS = {
		{8'h20, 1'b1, 2'd0, 8'h00, 8'h00},
		{8'h65, 1'b1, 2'd1, 8'h10, 8'h00},
		{8'hFF, 1'b1, 2'd1, 8'hFF, 8'h00},
		{8'h00, 1'b1, 2'd2, 8'hFF, 8'h00},
		{8'h80, 1'b1, 2'd1, 8'h0F, 8'h00},
		{8'h6D, 1'b1, 2'd1, 8'hE8, 8'h00},
		{8'h6D, 1'b1, 2'd0, 8'h00, 8'h00},
		{8'h7F, 1'b1, 2'd2, 8'hF0, 8'h7F},
		{8'h63, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'h6C, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'h75, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'h64, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'h01, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'h02, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'h04, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'h08, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'h10, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'h40, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'hAA, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'h55, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'hFE, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'h65, 1'b0, 2'd0, 8'h00, 8'h00},
		{8'h20, 1'b0, 2'd0, 8'h00, 8'h00}
	};

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [mtfne_pkg::ByteW-1:0] in_byte;
	logic                        out_valid;
	logic                        out_ready;
	logic [mtfne_pkg::ByteW-1:0] out_byte;
	logic                        last_of_run;

	logic [7:0]  mtf_list [TBL];
	logic [7:0]  acc_bits;
	int          acc_cnt;
	coded_word_t coded_q [$];
	stim_row_t   cur_row;
	int          errs;
	int          cycles;
	int          rx_done;

	mtf_nibble_encoder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic flag(input string msg);
		errs++;
		if (errs <= 10) begin
			$display("%s", msg);
		end
	endtask

	// one byte through the coder: returns the completed code bytes
	task automatic mtf_encode(input logic [7:0] b, output int n,
			output logic [7:0] r0, output logic [7:0] r1);
		int          hit;
		int          pos;
		logic [23:0] acc;
		hit = -1;
		for (int i = 0; i < TBL; i++) begin
			if (hit < 0 && mtf_list[i] == b) begin
				hit = i;
			end
		end
		acc = {16'h0, acc_bits};
		if (hit >= 0) begin
			acc = acc | ({20'h0, hit[3:0]} << acc_cnt);
			acc_cnt += 4;
		end else begin
			acc = acc | ({12'h0, b, mtfne_pkg::EscNibble} << acc_cnt);
			acc_cnt += 12;
		end
		pos = (hit >= 0) ? hit : TBL - 1;
		for (int i = pos; i > 0; i--) begin
			mtf_list[i] = mtf_list[i-1];
		end
		mtf_list[0] = b;
		r0 = acc[7:0];
		r1 = acc[15:8];
		n = acc_cnt / 8;
		acc = acc >> (8 * n);
		acc_bits = acc[7:0];
		acc_cnt -= 8 * n;
	endtask

	task automatic queue_words(input int n, input logic [7:0] r0, input logic [7:0] r1);
		if (n >= 1) begin
			coded_q.push_back('{data: r0, last: (n == 1)});
		end
		if (n == 2) begin
			coded_q.push_back('{data: r1, last: 1'b1});
		end
	endtask

	// scoreboard: outputs first, so a word leaving now belongs to an older byte
	always @(posedge clk) begin
		int          n;
		logic [7:0]  r0;
		logic [7:0]  r1;
		coded_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (coded_q.size() == 0) begin
				flag($sformatf("unexpected word: actual %02h last %0b", out_byte,
					last_of_run));
			end else begin
				want = coded_q.pop_front();
				if (out_byte !== want.data) begin
					flag($sformatf("out_byte: expected %02h actual %02h", want.data,
						out_byte));
				end
				if (last_of_run !== want.last) begin
					flag($sformatf("last_of_run: expected %0b actual %0b (byte %02h)",
						want.last, last_of_run, want.data));
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			mtf_encode(in_byte, n, r0, r1);
			if (cur_row.typed) begin
				queue_words(cur_row.n, cur_row.e0, cur_row.e1);
			end else begin
				queue_words(n, r0, r1);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random stalls, quiet stretches, and one long hold-off
	initial begin
		int  hold;
		bit  quiet;
		quiet = 1'b0;
		out_ready = 1'b0;
		rx_done = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_done[4:0] == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
			end
			if (rx_done == 60) begin
				hold = LONG_HLD;
			end else begin
				hold = quiet ? 0 : $urandom_range(0, 12);
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			rx_done++;
		end
	end

	initial begin
		int         gap;
		int         pick;
		bit         quiet;
		logic [7:0] b;
		stim_row_t  row;
		errs = 0;
		cycles = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = '0;
		cur_row = '0;
		for (int i = 0; i < TBL; i++) begin
			mtf_list[i] = DEF_LIST[(14-i)*8 +: 8];
		end
		acc_bits = '0;
		acc_cnt = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int k = 0; k < N_DIR + N_RAND; k++) begin
			if (k < N_DIR) begin
				row = DIR_ROWS[k];
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 5) begin
					b = DEF_LIST[$urandom_range(0, 14)*8 +: 8];
				end else if (pick < 7) begin
					b = 8'($urandom_range(0, 7));
				end else begin
					b = 8'($urandom_range(0, 255));
				end
				row = '{b: b, typed: 1'b0, n: 2'd0, e0: 8'h00, e1: 8'h00};
			end
			if (k % 40 == 0) begin
				quiet = ($urandom_range(0, 2) == 0);
			end
			gap = quiet ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte <= row.b;
			cur_row <= row;
			do @(posedge clk); while (!in_ready);
		end
		in_valid <= 1'b0;
		while (coded_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (coded_q.size() != 0) begin
			flag($sformatf("%0d words never arrived", coded_q.size()));
		end
		if (errs == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/mtfne_pkg.sv
rtl/mtfne_dp.sv
rtl/mtfne_ctrl.sv
rtl/mtf_nibble_encoder.sv
tb/sv/tb_mtf_nibble_encoder.sv
